/* hw/rtl/m2a_pkg.sv */
package m2a_pkg;

    // Number format and datapath widths
    localparam int WordBits     = 32;
    localparam int FracBits     = 16;
    localparam int ProdBits     = 2 * WordBits;
    localparam int SumBits      = ProdBits + 1;
    localparam int RndBits      = SumBits - FracBits;
    localparam int LinBits      = WordBits + 1;
    localparam int NumBits      = WordBits + FracBits;
    localparam int RemBits      = WordBits + 1;
    localparam int BitsPerStage = 2;
    localparam int DivStages    = NumBits / BitsPerStage;

    // Operation codes
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MATMUL = 4'd2;
    localparam logic [3:0] OP_MATVEC = 4'd3;
    localparam logic [3:0] OP_SCALE  = 4'd4;
    localparam logic [3:0] OP_DIVIDE = 4'd5;
    localparam logic [3:0] OP_TRANS  = 4'd6;
    localparam logic [3:0] OP_INV    = 4'd7;
    localparam logic [3:0] OP_DET    = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef logic signed [WordBits-1:0] word_t;

    typedef struct packed {
        word_t val;
        logic  ovf;
    } sat_t;

    // Payload that walks through the divider stages
    typedef struct packed {
        logic                               do_div;
        logic                               bad;
        logic                               ovf;
        logic [3:0][WordBits-1:0]           res;
        logic [3:0]                         neg;
        logic [WordBits-1:0]                dmag;
        logic [3:0][NumBits-1:0]            num;
        logic [3:0][RemBits-1:0]            rem;
        logic [3:0][NumBits-1:0]            quo;
    } div_t;

    // Clamp a rounded value into the word range
    function automatic sat_t saturate(input logic signed [RndBits-1:0] v);
        logic signed [RndBits-1:0] hi_lim;
        logic signed [RndBits-1:0] lo_lim;
        sat_t                      r;
        hi_lim = {{(RndBits-WordBits+1){1'b0}}, {(WordBits-1){1'b1}}};
        lo_lim = ~hi_lim;
        r.ovf  = 1'b0;
        r.val  = v[WordBits-1:0];
        if (v > hi_lim)
        begin
            r.ovf = 1'b1;
            r.val = hi_lim[WordBits-1:0];
        end
        else if (v < lo_lim)
        begin
            r.ovf = 1'b1;
            r.val = lo_lim[WordBits-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/m2a_in_if.sv */
interface m2a_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    m2a_pkg::word_t    a_r0c0;
    m2a_pkg::word_t    a_r0c1;
    m2a_pkg::word_t    a_r1c0;
    m2a_pkg::word_t    a_r1c1;
    m2a_pkg::word_t    b_r0c0;
    m2a_pkg::word_t    b_r0c1;
    m2a_pkg::word_t    b_r1c0;
    m2a_pkg::word_t    b_r1c1;
    m2a_pkg::word_t    scalar;

    modport source (output valid, action, a_r0c0, a_r0c1, a_r1c0, a_r1c1,
                    b_r0c0, b_r0c1, b_r1c0, b_r1c1, scalar, input ready);
    modport sink   (input valid, action, a_r0c0, a_r0c1, a_r1c0, a_r1c1,
                    b_r0c0, b_r0c1, b_r1c0, b_r1c1, scalar, output ready);
endinterface

/* hw/rtl/m2a_out_if.sv */
interface m2a_out_if;
    logic              valid;
    logic              ready;
    m2a_pkg::word_t    r_r0c0;
    m2a_pkg::word_t    r_r0c1;
    m2a_pkg::word_t    r_r1c0;
    m2a_pkg::word_t    r_r1c1;
    logic [1:0]        status;

    modport source (output valid, r_r0c0, r_r0c1, r_r1c0, r_r1c1, status, input ready);
    modport sink   (input valid, r_r0c0, r_r0c1, r_r1c0, r_r1c1, status, output ready);
endinterface

/* hw/rtl/m2a_front.sv */
module m2a_front (
    input  logic             clk,
    input  logic             rst_n,
    m2a_in_if.sink           item,
    output logic             out_valid,
    output m2a_pkg::div_t    out_data,
    input  logic             out_ready
);

    localparam int W = m2a_pkg::WordBits;

    // ---------------- stage 1: operand select and multiply ----------------
    m2a_pkg::word_t a [4];
    m2a_pkg::word_t b [4];
    m2a_pkg::word_t mx [8];
    m2a_pkg::word_t my [8];
    logic           sub_flag;
    logic signed [m2a_pkg::LinBits-1:0] lin [4];

    logic                               s1_valid_reg;
    logic [3:0]                         s1_action_reg;
    logic                               s1_sub_reg;
    logic signed [m2a_pkg::ProdBits-1:0] s1_prod_reg [8];
    logic signed [m2a_pkg::LinBits-1:0] s1_lin_reg [4];
    m2a_pkg::word_t                     s1_a_reg [4];
    m2a_pkg::word_t                     s1_s_reg;
    logic                               s1_ready;

    logic                               s2_valid_reg;
    logic [3:0]                         s2_action_reg;
    m2a_pkg::word_t                     s2_res_reg [4];
    logic                               s2_ovf_reg;
    m2a_pkg::word_t                     s2_det_reg;
    m2a_pkg::word_t                     s2_a_reg [4];
    m2a_pkg::word_t                     s2_s_reg;
    logic                               s2_ready;

    logic                               s3_valid_reg;
    m2a_pkg::div_t                      s3_data_reg;
    logic                               s3_ready;

    assign a[0] = item.a_r0c0;
    assign a[1] = item.a_r0c1;
    assign a[2] = item.a_r1c0;
    assign a[3] = item.a_r1c1;
    assign b[0] = item.b_r0c0;
    assign b[1] = item.b_r0c1;
    assign b[2] = item.b_r1c0;
    assign b[3] = item.b_r1c1;

    // pick multiplier operand pairs; pairs 2k and 2k+1 are summed or subtracted later
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            mx[k] = '0;
            my[k] = '0;
        end
        sub_flag = 1'b0;
        unique case (item.action)
            m2a_pkg::OP_MATMUL:
            begin
                mx[0] = a[0]; my[0] = b[0]; mx[1] = a[1]; my[1] = b[2];
                mx[2] = a[0]; my[2] = b[1]; mx[3] = a[1]; my[3] = b[3];
                mx[4] = a[2]; my[4] = b[0]; mx[5] = a[3]; my[5] = b[2];
                mx[6] = a[2]; my[6] = b[1]; mx[7] = a[3]; my[7] = b[3];
            end
            m2a_pkg::OP_MATVEC:
            begin
                mx[0] = a[0]; my[0] = b[0]; mx[1] = a[1]; my[1] = b[1];
                mx[2] = a[2]; my[2] = b[0]; mx[3] = a[3]; my[3] = b[1];
            end
            m2a_pkg::OP_SCALE:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    mx[2*k] = a[k];
                    my[2*k] = item.scalar;
                end
            end
            m2a_pkg::OP_INV, m2a_pkg::OP_DET:
            begin
                mx[0] = a[0]; my[0] = a[3]; mx[1] = a[2]; my[1] = a[1];
                sub_flag = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // element-wise add / subtract, one guard bit
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (item.action == m2a_pkg::OP_SUB)
                lin[k] = {a[k][W-1], a[k]} - {b[k][W-1], b[k]};
            else
                lin[k] = {a[k][W-1], a[k]} + {b[k][W-1], b[k]};
        end
    end

    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item.valid)
        begin
            s1_action_reg <= item.action;
            s1_sub_reg    <= sub_flag;
            s1_s_reg      <= item.scalar;
            for (int k = 0; k < 8; k++)
                s1_prod_reg[k] <= mx[k] * my[k];
            for (int k = 0; k < 4; k++)
            begin
                s1_lin_reg[k] <= lin[k];
                s1_a_reg[k]   <= a[k];
            end
        end
    end

    // ---------------- stage 2: sum, round, saturate, select ----------------
    logic signed [m2a_pkg::SumBits-1:0] sum [4];
    logic signed [m2a_pkg::RndBits-1:0] rnd [4];
    m2a_pkg::sat_t                      rs [4];
    m2a_pkg::sat_t                      ls [4];
    m2a_pkg::word_t                     res_next [4];
    logic                               ovf_next;

    always_comb
    begin
        logic signed [m2a_pkg::SumBits-1:0] half;
        logic signed [m2a_pkg::SumBits-1:0] rsum;
        half = m2a_pkg::SumBits'(1) << (m2a_pkg::FracBits - 1);
        for (int k = 0; k < 4; k++)
        begin
            if (s1_sub_reg)
                sum[k] = m2a_pkg::SumBits'(s1_prod_reg[2*k])
                       - m2a_pkg::SumBits'(s1_prod_reg[2*k+1]);
            else
                sum[k] = m2a_pkg::SumBits'(s1_prod_reg[2*k])
                       + m2a_pkg::SumBits'(s1_prod_reg[2*k+1]);
            rsum   = sum[k] + half;
            rnd[k] = rsum[m2a_pkg::SumBits-1:m2a_pkg::FracBits];
            rs[k]  = m2a_pkg::saturate(rnd[k]);
            ls[k]  = m2a_pkg::saturate(m2a_pkg::RndBits'(s1_lin_reg[k]));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            res_next[k] = '0;
        ovf_next = 1'b0;
        unique case (s1_action_reg)
            m2a_pkg::OP_ADD, m2a_pkg::OP_SUB:
            begin
                for (int k = 0; k < 4; k++)
                    res_next[k] = ls[k].val;
                ovf_next = ls[0].ovf | ls[1].ovf | ls[2].ovf | ls[3].ovf;
            end
            m2a_pkg::OP_MATMUL, m2a_pkg::OP_SCALE:
            begin
                for (int k = 0; k < 4; k++)
                    res_next[k] = rs[k].val;
                ovf_next = rs[0].ovf | rs[1].ovf | rs[2].ovf | rs[3].ovf;
            end
            m2a_pkg::OP_MATVEC:
            begin
                res_next[0] = rs[0].val;
                res_next[1] = rs[1].val;
                ovf_next    = rs[0].ovf | rs[1].ovf;
            end
            m2a_pkg::OP_DET, m2a_pkg::OP_INV:
            begin
                res_next[0] = rs[0].val;
                ovf_next    = rs[0].ovf;
            end
            m2a_pkg::OP_TRANS:
            begin
                res_next[0] = s1_a_reg[0];
                res_next[1] = s1_a_reg[2];
                res_next[2] = s1_a_reg[1];
                res_next[3] = s1_a_reg[3];
            end
            default:
            begin
            end
        endcase
    end

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_action_reg <= s1_action_reg;
            s2_ovf_reg    <= ovf_next;
            s2_det_reg    <= rs[0].val;
            s2_s_reg      <= s1_s_reg;
            for (int k = 0; k < 4; k++)
            begin
                s2_res_reg[k] <= res_next[k];
                s2_a_reg[k]   <= s1_a_reg[k];
            end
        end
    end

    // ---------------- stage 3: divider setup ----------------
    m2a_pkg::div_t                      d_next;

    always_comb
    begin
        logic                               is_div;
        logic                               is_inv;
        m2a_pkg::word_t                     den;
        logic signed [m2a_pkg::LinBits-1:0] n [4];
        logic signed [m2a_pkg::LinBits-1:0] dn;
        logic signed [m2a_pkg::LinBits-1:0] nabs;
        is_div = (s2_action_reg == m2a_pkg::OP_DIVIDE);
        is_inv = (s2_action_reg == m2a_pkg::OP_INV);
        den    = is_inv ? s2_det_reg : s2_s_reg;
        for (int k = 0; k < 4; k++)
            n[k] = {s2_a_reg[k][W-1], s2_a_reg[k]};
        if (is_inv)
        begin
            n[0] = {s2_a_reg[3][W-1], s2_a_reg[3]};
            n[1] = -{s2_a_reg[1][W-1], s2_a_reg[1]};
            n[2] = -{s2_a_reg[2][W-1], s2_a_reg[2]};
            n[3] = {s2_a_reg[0][W-1], s2_a_reg[0]};
        end
        dn = {den[W-1], den};
        if (dn < 0)
            dn = -dn;
        d_next.bad    = (is_div || is_inv) && (den == '0);
        d_next.do_div = (is_div || is_inv) && (den != '0);
        d_next.ovf    = is_div ? 1'b0 : s2_ovf_reg;
        d_next.dmag   = dn[W-1:0];
        for (int k = 0; k < 4; k++)
        begin
            nabs             = (n[k] < 0) ? -n[k] : n[k];
            d_next.num[k]    = {nabs[W-1:0], {m2a_pkg::FracBits{1'b0}}};
            d_next.neg[k]    = n[k][m2a_pkg::LinBits-1] ^ den[W-1];
            d_next.rem[k]    = '0;
            d_next.quo[k]    = '0;
            d_next.res[k]    = d_next.bad ? s2_a_reg[k] : s2_res_reg[k];
        end
    end

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ready)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
            s3_data_reg <= d_next;
    end

endmodule

/* hw/rtl/m2a_div_stage.sv */
module m2a_div_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  m2a_pkg::div_t    in_data,
    output logic             in_ready,
    output logic             out_valid,
    output m2a_pkg::div_t    out_data,
    input  logic             out_ready
);

    logic             valid_reg;
    m2a_pkg::div_t    data_reg;
    m2a_pkg::div_t    data_next;

    // restoring division, BitsPerStage quotient bits per stage on all four lanes
    always_comb
    begin
        logic [m2a_pkg::RemBits-1:0] rt;
        data_next = in_data;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < m2a_pkg::BitsPerStage; j++)
            begin
                rt = {data_next.rem[k][m2a_pkg::RemBits-2:0],
                      data_next.num[k][m2a_pkg::NumBits-1]};
                data_next.num[k] = {data_next.num[k][m2a_pkg::NumBits-2:0], 1'b0};
                if (rt >= {1'b0, data_next.dmag})
                begin
                    data_next.rem[k] = rt - {1'b0, data_next.dmag};
                    data_next.quo[k] = {data_next.quo[k][m2a_pkg::NumBits-2:0], 1'b1};
                end
                else
                begin
                    data_next.rem[k] = rt;
                    data_next.quo[k] = {data_next.quo[k][m2a_pkg::NumBits-2:0], 1'b0};
                end
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* hw/rtl/matrix2x2_arith_unit_top.sv */
// 2x2 matrix arithmetic unit, signed Q16.16.
// Channels: "item" carries one beat per operation (action, matrix A,
// matrix B or vector, scalar); "result" returns one beat per item with
// the 2x2 result and a status (ok, singular/zero divisor, saturated).
// Both channels use valid/ready; a beat moves when both are high.
// From item accept to result valid, an item passes through 28 register
// stages: three front stages (multiply, round/saturate, divider setup),
// 24 divider stages retiring two quotient bits each, and the output register.
// Throughput: one item per cycle for every action while result ready is high;
// the divider stages run on every item, so no action takes longer than another.
// Reset clears all stage valid bits; nothing is in flight afterwards.
// When the receiver stalls, each stage holds its beat and stages behind
// it keep filling empty slots; the item side drops ready only once the
// whole pipeline is full. No beat is lost or repeated.
module matrix2x2_arith_unit_top (
    input  logic      clk,
    input  logic      rst_n,
    m2a_in_if.sink    item,
    m2a_out_if.source result
);

    localparam int N = m2a_pkg::DivStages;
    localparam int W = m2a_pkg::WordBits;

    logic             stg_valid [N+1];
    logic             stg_ready [N+1];
    m2a_pkg::div_t    stg_data  [N+1];

    m2a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .out_valid (stg_valid[0]),
        .out_data  (stg_data[0]),
        .out_ready (stg_ready[0])
    );

    for (genvar g = 0; g < N; g++)
    begin : g_div
        m2a_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_data   (stg_data[g]),
            .in_ready  (stg_ready[g]),
            .out_valid (stg_valid[g+1]),
            .out_data  (stg_data[g+1]),
            .out_ready (stg_ready[g+1])
        );
    end

    // quotient sign and saturation, final status
    m2a_pkg::word_t   res_next [4];
    logic [1:0]       status_next;

    always_comb
    begin
        logic [m2a_pkg::NumBits-1:0] q;
        logic [m2a_pkg::NumBits-1:0] pos_lim;
        logic                        ovf;
        pos_lim = {{(m2a_pkg::NumBits-W+1){1'b0}}, {(W-1){1'b1}}};
        ovf     = stg_data[N].ovf;
        for (int k = 0; k < 4; k++)
        begin
            q           = stg_data[N].quo[k];
            res_next[k] = stg_data[N].res[k];
            if (stg_data[N].do_div)
            begin
                if (stg_data[N].neg[k])
                begin
                    if (q > pos_lim + 1'b1)
                    begin
                        ovf         = 1'b1;
                        res_next[k] = {1'b1, {(W-1){1'b0}}};
                    end
                    else
                        res_next[k] = -q[W-1:0];
                end
                else
                begin
                    if (q > pos_lim)
                    begin
                        ovf         = 1'b1;
                        res_next[k] = {1'b0, {(W-1){1'b1}}};
                    end
                    else
                        res_next[k] = q[W-1:0];
                end
            end
        end
        priority if (stg_data[N].bad)
            status_next = m2a_pkg::ST_BAD;
        else if (ovf)
            status_next = m2a_pkg::ST_SAT;
        else
            status_next = m2a_pkg::ST_OK;
    end

    // output register
    logic             out_valid_reg;
    m2a_pkg::word_t   out_res_reg [4];
    logic [1:0]       out_status_reg;

    assign stg_ready[N] = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stg_ready[N])
            out_valid_reg <= stg_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[N] && stg_valid[N])
        begin
            out_status_reg <= status_next;
            for (int k = 0; k < 4; k++)
                out_res_reg[k] <= res_next[k];
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.r_r0c0 = out_res_reg[0];
    assign result.r_r0c1 = out_res_reg[1];
    assign result.r_r1c0 = out_res_reg[2];
    assign result.r_r1c1 = out_res_reg[3];
    assign result.status = out_status_reg;

endmodule

/* sim/matrix2x2_arith_unit_top_tb.sv */
module matrix2x2_arith_unit_top_tb;

    typedef logic signed [127:0] big_t;

    typedef struct {
        logic [3:0]     action;
        m2a_pkg::word_t a [4];
        m2a_pkg::word_t b [4];
        m2a_pkg::word_t scalar;
    } op_item_t;

    typedef struct {
        m2a_pkg::word_t r [4];
        logic [1:0]     status;
    } op_result_t;

    localparam m2a_pkg::word_t W_MAX = 32'sh7fffffff;
    localparam m2a_pkg::word_t W_MIN = 32'sh80000000;
    localparam m2a_pkg::word_t W_ONE = 32'sh00010000;
    localparam int    NUM_RANDOM = 950;
    localparam int    DRAIN_AT = 400;

    logic clk;
    logic rst_n;

    m2a_in_if  item_if ();
    m2a_out_if result_if ();

    matrix2x2_arith_unit_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    op_item_t   pending_items [$];
    op_result_t expected_results [$];
    op_item_t   on_bus;
    int         send_gap;
    int         sent_cnt;
    int         recv_stall;
    int         recv_cnt;
    int         errors;

    // Clamp to the word range, note saturation
    function automatic m2a_pkg::word_t clamp_word(input big_t v, inout logic ovf);
        big_t hi_lim;
        big_t lo_lim;
        hi_lim = big_t'(W_MAX);
        lo_lim = big_t'(W_MIN);
        if (v > hi_lim)
        begin
            ovf = 1'b1;
            return W_MAX;
        end
        if (v < lo_lim)
        begin
            ovf = 1'b1;
            return W_MIN;
        end
        return m2a_pkg::word_t'(v[31:0]);
    endfunction

    // a*b + c*d, round half up at the binary point, clamp
    function automatic m2a_pkg::word_t fx_dot(input big_t a, input big_t b, input big_t c,
                                              input big_t d, inout logic ovf);
        big_t s;
        s = a * b + c * d;
        s = (s + (big_t'(1) <<< (m2a_pkg::FracBits - 1))) >>> m2a_pkg::FracBits;
        return clamp_word(s, ovf);
    endfunction

    // (n << frac) / d truncated toward zero, clamp
    function automatic m2a_pkg::word_t fx_div(input big_t n, input big_t d, inout logic ovf);
        big_t q;
        q = (n <<< m2a_pkg::FracBits) / d;
        return clamp_word(q, ovf);
    endfunction

    function automatic op_result_t compute_result(input op_item_t it);
        op_result_t     res;
        big_t           a [4];
        big_t           b [4];
        big_t           s;
        big_t           det;
        m2a_pkg::word_t dq;
        logic           ovf;
        logic           bad;
        ovf = 1'b0;
        bad = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = big_t'(it.a[i]);
            b[i] = big_t'(it.b[i]);
            res.r[i] = '0;
        end
        s = big_t'(it.scalar);
        case (it.action)
            m2a_pkg::OP_ADD:
                for (int i = 0; i < 4; i++) res.r[i] = clamp_word(a[i] + b[i], ovf);
            m2a_pkg::OP_SUB:
                for (int i = 0; i < 4; i++) res.r[i] = clamp_word(a[i] - b[i], ovf);
            m2a_pkg::OP_MATMUL:
            begin
                res.r[0] = fx_dot(a[0], b[0], a[1], b[2], ovf);
                res.r[1] = fx_dot(a[0], b[1], a[1], b[3], ovf);
                res.r[2] = fx_dot(a[2], b[0], a[3], b[2], ovf);
                res.r[3] = fx_dot(a[2], b[1], a[3], b[3], ovf);
            end
            m2a_pkg::OP_MATVEC:
            begin
                res.r[0] = fx_dot(a[0], b[0], a[1], b[1], ovf);
                res.r[1] = fx_dot(a[2], b[0], a[3], b[1], ovf);
            end
            m2a_pkg::OP_SCALE:
                for (int i = 0; i < 4; i++) res.r[i] = fx_dot(a[i], s, 0, 0, ovf);
            m2a_pkg::OP_DIVIDE:
            begin
                // zero divisor hands A back untouched
                if (s == 0)
                begin
                    bad = 1'b1;
                    for (int i = 0; i < 4; i++) res.r[i] = it.a[i];
                end
                else
                    for (int i = 0; i < 4; i++) res.r[i] = fx_div(a[i], s, ovf);
            end
            m2a_pkg::OP_TRANS:
            begin
                res.r[0] = it.a[0];
                res.r[1] = it.a[2];
                res.r[2] = it.a[1];
                res.r[3] = it.a[3];
            end
            m2a_pkg::OP_INV:
            begin
                dq = fx_dot(a[0], a[3], -a[2], a[1], ovf);
                if (dq == 0)
                begin
                    bad = 1'b1;
                    for (int i = 0; i < 4; i++) res.r[i] = it.a[i];
                end
                else
                begin
                    det = big_t'(dq);
                    res.r[0] = fx_div(a[3], det, ovf);
                    res.r[1] = fx_div(-a[1], det, ovf);
                    res.r[2] = fx_div(-a[2], det, ovf);
                    res.r[3] = fx_div(a[0], det, ovf);
                end
            end
            m2a_pkg::OP_DET:
                res.r[0] = fx_dot(a[0], a[3], -a[2], a[1], ovf);
            default: ;
        endcase
        res.status = bad ? m2a_pkg::ST_BAD : (ovf ? m2a_pkg::ST_SAT : m2a_pkg::ST_OK);
        return res;
    endfunction

    // Mix of corner values, small Q16.16 values and raw words
    function automatic m2a_pkg::word_t pick_word();
        m2a_pkg::word_t corners [8];
        int             sel;
        corners = '{32'sd0, 32'sd1, -32'sd1, W_MAX, W_MIN, W_ONE, -W_ONE, 32'sh00008000};
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return corners[$urandom_range(0, 7)];
        if (sel < 7)
            return m2a_pkg::word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        return m2a_pkg::word_t'($urandom);
    endfunction

    function automatic op_item_t make_item(input logic [3:0] act, input m2a_pkg::word_t a0,
                                           input m2a_pkg::word_t a1, input m2a_pkg::word_t a2,
                                           input m2a_pkg::word_t a3, input m2a_pkg::word_t b0,
                                           input m2a_pkg::word_t b1, input m2a_pkg::word_t b2,
                                           input m2a_pkg::word_t b3, input m2a_pkg::word_t sc);
        op_item_t it;
        it.action = act;
        it.a = '{a0, a1, a2, a3};
        it.b = '{b0, b1, b2, b3};
        it.scalar = sc;
        return it;
    endfunction

    function automatic op_item_t random_item();
        op_item_t       it;
        m2a_pkg::word_t k;
        it.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        for (int i = 0; i < 4; i++)
        begin
            it.a[i] = pick_word();
            it.b[i] = pick_word();
        end
        it.scalar = ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_word();
        // singular A: second row a multiple of the first
        if ((it.action == m2a_pkg::OP_INV || it.action == m2a_pkg::OP_DET) &&
            $urandom_range(0, 3) == 0)
        begin
            k = m2a_pkg::word_t'($urandom_range(0, 8)) - 32'sd4;
            it.a[0] = m2a_pkg::word_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            it.a[1] = m2a_pkg::word_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            it.a[2] = it.a[0] * k;
            it.a[3] = it.a[1] * k;
        end
        return it;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reset and stimulus
    initial
    begin
        rst_n = 1'b0;
        pending_items.push_back(make_item(m2a_pkg::OP_ADD, W_MAX, W_MIN, W_ONE, 0,
                                          W_MAX, W_MIN, -W_ONE, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_SUB, W_MIN, W_MAX, 0, 5,
                                          W_MAX, W_MIN, 0, -1, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_MATMUL, W_ONE, 0, 0, W_ONE,
                                          32'sh0003_8000, -7, W_MAX, W_MIN, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_MATMUL, W_MAX, W_MAX, W_MIN, W_MIN,
                                          W_MAX, W_MIN, W_MAX, W_MIN, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_MATVEC, 2 * W_ONE, W_ONE, -W_ONE,
                                          3 * W_ONE, W_ONE, 32'sh0000_8000, W_MAX, W_MIN, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_SCALE, W_MAX, W_MIN, 1, -1,
                                          0, 0, 0, 0, 32'sh0000_8000));
        pending_items.push_back(make_item(m2a_pkg::OP_SCALE, W_MAX, W_MIN, W_ONE, 3,
                                          0, 0, 0, 0, W_MIN));
        pending_items.push_back(make_item(m2a_pkg::OP_DIVIDE, W_ONE, W_MIN, 7, -7,
                                          0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_DIVIDE, W_MAX, W_MIN, 3 * W_ONE, -1,
                                          0, 0, 0, 0, 3));
        pending_items.push_back(make_item(m2a_pkg::OP_DIVIDE, W_MIN, W_MAX, -W_ONE, 5,
                                          0, 0, 0, 0, -1));
        pending_items.push_back(make_item(m2a_pkg::OP_TRANS, W_MAX, W_MIN, -1, 1,
                                          0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_INV, W_ONE, 2 * W_ONE, 2 * W_ONE,
                                          4 * W_ONE, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_INV, 1, 0, 0, 1,
                                          0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_INV, 2 * W_ONE, W_ONE, W_ONE,
                                          3 * W_ONE, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_INV, W_MIN, W_MAX, W_MAX, W_MIN,
                                          0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_DET, W_MAX, W_MIN, W_MIN, W_MAX,
                                          0, 0, 0, 0, 0));
        pending_items.push_back(make_item(m2a_pkg::OP_DET, 3 * W_ONE, W_ONE, 2 * W_ONE,
                                          -W_ONE, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(4'd9, W_MAX, 1, 2, 3, 4, 5, 6, 7, 8));
        pending_items.push_back(make_item(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_items.push_back(random_item());
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all beats sent and all results back
        while (pending_items.size() != 0 || item_if.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Timeout
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Item driver; predicts each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid  <= 1'b0;
            item_if.action <= '0;
            item_if.a_r0c0 <= '0;
            item_if.a_r0c1 <= '0;
            item_if.a_r1c0 <= '0;
            item_if.a_r1c1 <= '0;
            item_if.b_r0c0 <= '0;
            item_if.b_r0c1 <= '0;
            item_if.b_r1c0 <= '0;
            item_if.b_r1c1 <= '0;
            item_if.scalar <= '0;
            send_gap <= 0;
            sent_cnt <= 0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
            begin
                expected_results.push_back(compute_result(on_bus));
                sent_cnt <= sent_cnt + 1;
            end
            if (item_if.valid && !item_if.ready)
                ;
            else if (send_gap > 0)
            begin
                item_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (sent_cnt + (item_if.valid ? 1 : 0) == DRAIN_AT &&
                     expected_results.size() != 0)
                item_if.valid <= 1'b0;
            else if (pending_items.size() != 0)
            begin
                on_bus = pending_items.pop_front();
                item_if.valid  <= 1'b1;
                item_if.action <= on_bus.action;
                item_if.a_r0c0 <= on_bus.a[0];
                item_if.a_r0c1 <= on_bus.a[1];
                item_if.a_r1c0 <= on_bus.a[2];
                item_if.a_r1c1 <= on_bus.a[3];
                item_if.b_r0c0 <= on_bus.b[0];
                item_if.b_r0c1 <= on_bus.b[1];
                item_if.b_r1c0 <= on_bus.b[2];
                item_if.b_r1c1 <= on_bus.b[3];
                item_if.scalar <= on_bus.scalar;
                // back-to-back stretches between idle ones
                send_gap <= (sent_cnt % 150 < 40) ? 0 : $urandom_range(0, 14);
            end
            else
                item_if.valid <= 1'b0;
        end
    end

    // Result side: random stalls, compare against oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        op_result_t     want;
        m2a_pkg::word_t got [4];
        int             bad_cnt;
        int             wait_cycles;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            recv_stall <= 0;
            recv_cnt <= 0;
            errors <= 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                bad_cnt = 0;
                recv_cnt <= recv_cnt + 1;
                got = '{result_if.r_r0c0, result_if.r_r0c1,
                        result_if.r_r1c0, result_if.r_r1c1};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat r0c0=%h status=%0d",
                             $time, got[0], result_if.status);
                    bad_cnt = bad_cnt + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want.r[i])
                        begin
                            $display("%0t: element %0d expected %h actual %h",
                                     $time, i, want.r[i], got[i]);
                            bad_cnt = bad_cnt + 1;
                        end
                    if (result_if.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result_if.status);
                        bad_cnt = bad_cnt + 1;
                    end
                end
                errors <= errors + bad_cnt;
                wait_cycles = (recv_cnt % 130 < 35) ? 0 : $urandom_range(0, 14);
                recv_stall <= wait_cycles;
                result_if.ready <= (wait_cycles == 0);
            end
            else if (recv_stall > 0)
            begin
                result_if.ready <= (recv_stall == 1);
                recv_stall <= recv_stall - 1;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

endmodule

/* sim.f */
hw/rtl/m2a_pkg.sv
hw/rtl/m2a_in_if.sv
hw/rtl/m2a_out_if.sv
hw/rtl/m2a_front.sv
hw/rtl/m2a_div_stage.sv
hw/rtl/matrix2x2_arith_unit_top.sv
sim/matrix2x2_arith_unit_top_tb.sv
